// File: design/flac_metadata_locator_top_assert.svh
// Assertion macros for the metadata locator top level.
`ifndef FLAC_METADATA_LOCATOR_TOP_ASSERT_SVH
`define FLAC_METADATA_LOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define FLM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, quiet while reset is high.
`define FLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: design/flm_pkg.sv
`timescale 1ns / 1ps

package flm_pkg;

   localparam int FLM_MAX_SEARCH = 8192;
   localparam int LIMIT_W        = 17;

   localparam logic [23:0] SIG_HEAD     = 24'h664C61;
   localparam logic [7:0]  SIG_TAIL     = 8'h43;
   localparam logic [6:0]  TYPE_COMMENT = 7'd4;
   localparam int          INFO_RATE_AT = 14;
   localparam int          INFO_SIZE    = 38;
   localparam int          DIV_STEPS    = 36;

   localparam logic [2:0] STATUS_COMMENT    = 3'd0;
   localparam logic [2:0] STATUS_NO_SIG     = 3'd1;
   localparam logic [2:0] STATUS_NOT_INFO   = 3'd2;
   localparam logic [2:0] STATUS_NO_COMMENT = 3'd3;
   localparam logic [2:0] STATUS_EARLY_EOF  = 3'd4;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_INFO,
      PH_HEADER,
      PH_SKIP,
      PH_DONE
   } flm_phase_type;

   typedef enum logic {
      FLOW_RUN,
      FLOW_DIVIDE
   } flm_flow_type;

   // result produced by the byte now on the input
   typedef struct packed {
      logic        emit;
      logic        timing;
      logic [2:0]  status;
      logic [31:0] offset;
      logic [19:0] rate;
      logic [35:0] samples;
   } flm_event_type;

   typedef struct packed {
      logic emit;
      logic need_div;
      logic reported;
   } flm_pstat_type;

   typedef struct packed {
      logic take_byte;
      logic load_result;
      logic start_div;
   } flm_cmd_type;

   typedef struct packed {
      logic valid;
      logic busy;
      logic div_done;
   } flm_rstat_type;

endpackage

// File: design/flm_channels.sv
`timescale 1ns / 1ps

interface flm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface flm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] comment_offset;
   logic [35:0] duration_seconds;
   logic [19:0] sample_rate;
   logic        rate_zero;

   modport source (output valid, output status, output comment_offset,
                   output duration_seconds, output sample_rate, output rate_zero,
                   input ready);
   modport sink   (input valid, input status, input comment_offset,
                   input duration_seconds, input sample_rate, input rate_zero,
                   output ready);
endinterface

// File: design/flac_metadata_locator_top.sv
`timescale 1ns / 1ps
// Channel | Role   | Beat
// req     | sink   | data_byte, end_of_file (one file byte)
// rsp     | source | status, comment_offset, duration_seconds, sample_rate, rate_zero
// csr     | write  | search_limit, taken on every clock with csr_write_enable high
//
// One byte per cycle. A result with a nonzero sample rate goes through
// the shared restoring divider (one quotient bit per cycle); req is held off
// meanwhile. Synchronous reset clears the parser and sets search_limit to
// MAX_SEARCH. A result waiting on rsp holds off req unless the current file
// has already reported; later bytes of that file are taken and dropped.

module flac_metadata_locator_top #(
   parameter int MAX_SEARCH = flm_pkg::FLM_MAX_SEARCH
) (
   input  logic        clock,
   input  logic        reset,
   flm_req_if.sink     req,
   flm_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data
);
   import flm_pkg::*;
`include "flac_metadata_locator_top_assert.svh"

   flm_cmd_type   cmd;
   flm_event_type evt;
   flm_pstat_type pstat;
   flm_rstat_type rstat;
   logic          ready;

   assign req.ready = ready;

   flm_parser #(
      .MAX_SEARCH (MAX_SEARCH)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .data_byte        (req.data_byte),
      .end_of_file      (req.end_of_file),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .evt              (evt),
      .pstat            (pstat)
   );

   flm_result u_result (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .evt   (evt),
      .rstat (rstat),
      .rsp   (rsp)
   );

   flm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .pstat     (pstat),
      .rstat     (rstat),
      .cmd       (cmd)
   );

   `FLM_ASSERT_IMPLY(a_no_byte_while_dividing, clock, reset, rstat.busy, !ready)
   `FLM_ASSERT_IMPLY(a_load_into_empty, clock, reset, cmd.load_result, !rstat.valid && !rstat.busy)
   `FLM_ASSERT_NEXT(a_div_starts, clock, reset, cmd.start_div, rstat.busy && !rstat.valid)
   `FLM_ASSERT_IMPLY(a_zero_rate_no_duration, clock, reset, rsp.valid && rsp.rate_zero, rsp.duration_seconds == 36'd0)

endmodule

// File: design/flm_parser.sv
`timescale 1ns / 1ps

module flm_parser #(
   parameter int MAX_SEARCH = flm_pkg::FLM_MAX_SEARCH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  flm_pkg::flm_cmd_type  cmd,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_file,
   input  logic                  csr_write_enable,
   input  logic [16:0]           csr_write_data,
   output flm_pkg::flm_event_type evt,
   output flm_pkg::flm_pstat_type pstat
);
   import flm_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic [31:0]        pos_ff,     pos_in;
   logic [23:0]        recent_ff,  recent_in;
   flm_phase_type      phase_ff,   phase_in;
   logic [23:0]        cnt_ff,     cnt_in;
   logic [31:0]        hdr_ff,     hdr_in;
   logic               last_ff,    last_in;
   logic [23:0]        rate_ff,    rate_in;
   logic [35:0]        samples_ff, samples_in;

   logic        sig_hit;
   logic        window_over;
   logic [31:0] pos_next;
   logic [23:0] idx_next;
   logic [23:0] recent_shift;
   logic [23:0] skip_left;

   assign pos_next     = pos_ff + 32'd1;
   assign idx_next     = cnt_ff + 24'd1;
   assign recent_shift = {recent_ff[15:0], data_byte};
   assign skip_left    = cnt_ff - 24'd1;

   assign sig_hit = (recent_ff == SIG_HEAD) && (data_byte == SIG_TAIL) &&
                    (pos_ff >= 32'd3) &&
                    ((pos_ff - 32'd3) < {{(32-LIMIT_W){1'b0}}, limit_ff});
   assign window_over = ({1'b0, pos_ff} + 33'd1) >=
                        ({{(33-LIMIT_W){1'b0}}, limit_ff} + 33'd3);

   always_comb begin
      pos_in     = pos_ff;
      recent_in  = recent_ff;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      hdr_in     = hdr_ff;
      last_in    = last_ff;
      rate_in    = rate_ff;
      samples_in = samples_ff;
      evt         = '0;
      evt.offset  = '0;
      evt.rate    = rate_ff[19:0];
      evt.samples = samples_ff;
      evt.status  = STATUS_COMMENT;

      if (cmd.take_byte) begin
         pos_in = pos_next;
         unique case (phase_ff)
            PH_SEARCH: begin
               if (sig_hit) begin
                  phase_in = PH_INFO;
                  cnt_in   = '0;
                  hdr_in   = pos_next;
               end else if (window_over) begin
                  evt.emit   = 1'b1;
                  evt.status = STATUS_NO_SIG;
               end
               recent_in = recent_shift;
            end
            PH_INFO: begin
               if (cnt_ff == 24'd0) begin
                  last_in = data_byte[7];
                  if (data_byte[6:0] != 7'd0) begin
                     evt.emit   = 1'b1;
                     evt.status = STATUS_NOT_INFO;
                  end
               end else if (cnt_ff >= 24'(INFO_RATE_AT) && cnt_ff < 24'(INFO_RATE_AT + 3)) begin
                  if (cnt_ff == 24'(INFO_RATE_AT + 2)) begin
                     rate_in = {4'd0, rate_ff[15:0], data_byte[7:4]};
                  end else begin
                     rate_in = {rate_ff[15:0], data_byte};
                  end
               end else if (cnt_ff >= 24'(INFO_RATE_AT + 3) && cnt_ff < 24'(INFO_SIZE - 16)) begin
                  if (cnt_ff == 24'(INFO_RATE_AT + 3)) begin
                     samples_in = {32'd0, data_byte[3:0]};
                  end else begin
                     samples_in = {samples_ff[27:0], data_byte};
                  end
               end
               if (!evt.emit) begin
                  if (idx_next >= 24'(INFO_SIZE)) begin
                     if (last_ff) begin
                        evt.emit   = 1'b1;
                        evt.timing = 1'b1;
                        evt.status = STATUS_NO_COMMENT;
                     end else begin
                        phase_in = PH_HEADER;
                        cnt_in   = '0;
                        hdr_in   = pos_next;
                     end
                  end else begin
                     cnt_in = idx_next;
                  end
               end
            end
            PH_HEADER: begin
               if (cnt_ff == 24'd0) begin
                  if (data_byte[6:0] == TYPE_COMMENT) begin
                     evt.emit   = 1'b1;
                     evt.timing = 1'b1;
                     evt.status = STATUS_COMMENT;
                     evt.offset = hdr_ff + 32'd4;
                  end else if (data_byte[7]) begin
                     evt.emit   = 1'b1;
                     evt.timing = 1'b1;
                     evt.status = STATUS_NO_COMMENT;
                  end else begin
                     recent_in = '0;
                     cnt_in    = 24'd1;
                  end
               end else begin
                  recent_in = recent_shift;
                  if (cnt_ff >= 24'd3) begin
                     // zero-length body: next byte is a header again
                     if (recent_shift == 24'd0) begin
                        cnt_in = '0;
                        hdr_in = pos_next;
                     end else begin
                        phase_in = PH_SKIP;
                        cnt_in   = recent_shift;
                     end
                  end else begin
                     cnt_in = idx_next;
                  end
               end
            end
            PH_SKIP: begin
               cnt_in = skip_left;
               if (skip_left == 24'd0) begin
                  phase_in = PH_HEADER;
                  hdr_in   = pos_next;
               end
            end
            PH_DONE: begin
            end
         endcase

         if (evt.emit) begin
            phase_in = PH_DONE;
         end

         if (end_of_file) begin
            // judge by the phase this byte leads to
            if (phase_ff != PH_DONE && !evt.emit) begin
               evt.emit   = 1'b1;
               evt.timing = 1'b0;
               evt.status = (phase_in == PH_SEARCH) ? STATUS_NO_SIG : STATUS_EARLY_EOF;
            end
            // rearm for the next file
            pos_in     = '0;
            recent_in  = '0;
            phase_in   = PH_SEARCH;
            cnt_in     = '0;
            hdr_in     = '0;
            last_in    = 1'b0;
            rate_in    = '0;
            samples_in = '0;
         end
      end

      if (!evt.timing) begin
         evt.rate    = '0;
         evt.samples = '0;
      end
   end

   assign pstat.emit     = evt.emit;
   assign pstat.need_div = evt.timing && (evt.rate != 20'd0);
   assign pstat.reported = (phase_ff == PH_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_W'(MAX_SEARCH);
         pos_ff     <= '0;
         recent_ff  <= '0;
         phase_ff   <= PH_SEARCH;
         cnt_ff     <= '0;
         hdr_ff     <= '0;
         last_ff    <= 1'b0;
         rate_ff    <= '0;
         samples_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         pos_ff     <= pos_in;
         recent_ff  <= recent_in;
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         hdr_ff     <= hdr_in;
         last_ff    <= last_in;
         rate_ff    <= rate_in;
         samples_ff <= samples_in;
      end
   end

endmodule

// File: design/flm_result.sv
`timescale 1ns / 1ps

module flm_result (
   input  logic                   clock,
   input  logic                   reset,
   input  flm_pkg::flm_cmd_type   cmd,
   input  flm_pkg::flm_event_type evt,
   output flm_pkg::flm_rstat_type rstat,
   flm_rsp_if.source              rsp
);
   import flm_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic              valid_ff,   valid_in;
   logic              busy_ff,    busy_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic [19:0]       rem_ff,     rem_in;
   logic [35:0]       quo_ff,     quo_in;
   logic [19:0]       dsr_ff,     dsr_in;
   logic [2:0]        status_ff,  status_in;
   logic [31:0]       offset_ff,  offset_in;
   logic [19:0]       srate_ff,   srate_in;
   logic              rzero_ff,   rzero_in;
   logic [35:0]       dur_ff,     dur_in;

   logic [20:0] rem_sh;
   logic [20:0] diff;
   logic        fits;
   logic        last_step;

   // one quotient bit per cycle, restoring form
   assign rem_sh    = {rem_ff, quo_ff[35]};
   assign diff      = rem_sh - {1'b0, dsr_ff};
   assign fits      = rem_sh >= {1'b0, dsr_ff};
   assign last_step = busy_ff && (count_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      valid_in  = valid_ff;
      busy_in   = busy_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      status_in = status_ff;
      offset_in = offset_ff;
      srate_in  = srate_ff;
      rzero_in  = rzero_ff;
      dur_in    = dur_ff;

      if (valid_ff && rsp.ready) begin
         valid_in = 1'b0;
      end

      if (busy_ff) begin
         rem_in   = fits ? diff[19:0] : rem_sh[19:0];
         quo_in   = {quo_ff[34:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (last_step) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
            dur_in   = {quo_ff[34:0], fits};
         end
      end

      if (cmd.load_result) begin
         status_in = evt.status;
         offset_in = evt.offset;
         srate_in  = evt.rate;
         rzero_in  = evt.timing && (evt.rate == 20'd0);
         dur_in    = '0;
         if (cmd.start_div) begin
            busy_in  = 1'b1;
            count_in = '0;
            rem_in   = '0;
            quo_in   = evt.samples;
            dsr_in   = evt.rate;
         end else begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dsr_ff    <= dsr_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      srate_ff  <= srate_in;
      rzero_ff  <= rzero_in;
      dur_ff    <= dur_in;
   end

   assign rstat.valid    = valid_ff;
   assign rstat.busy     = busy_ff;
   assign rstat.div_done = last_step;

   assign rsp.valid            = valid_ff;
   assign rsp.status           = status_ff;
   assign rsp.comment_offset   = offset_ff;
   assign rsp.duration_seconds = dur_ff;
   assign rsp.sample_rate      = srate_ff;
   assign rsp.rate_zero        = rzero_ff;

endmodule

// File: design/flm_ctrl.sv
`timescale 1ns / 1ps

module flm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  flm_pkg::flm_pstat_type pstat,
   input  flm_pkg::flm_rstat_type rstat,
   output flm_pkg::flm_cmd_type   cmd
);
   import flm_pkg::*;

   flm_flow_type flow_ff, flow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_ff <= FLOW_RUN;
      end else begin
         flow_ff <= flow_in;
      end
   end

   always_comb begin
      flow_in   = flow_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (flow_ff)
         FLOW_RUN: begin
            // after a report no byte can produce a beat, so keep taking bytes
            req_ready = !rstat.valid || pstat.reported;
            if (req_valid && req_ready) begin
               cmd.take_byte = 1'b1;
               if (pstat.emit) begin
                  cmd.load_result = 1'b1;
                  cmd.start_div   = pstat.need_div;
                  if (pstat.need_div) begin
                     flow_in = FLOW_DIVIDE;
                  end
               end
            end
         end
         FLOW_DIVIDE: begin
            if (rstat.div_done) begin
               flow_in = FLOW_RUN;
            end
         end
      endcase
   end

endmodule

// File: bench/flm_locator_checker.sv
`timescale 1ns / 1ps

module flm_locator_checker #(
   parameter int MAX_SEARCH = flm_pkg::FLM_MAX_SEARCH
) (
   input  logic        clock,
   input  logic        reset,
   flm_req_if          req,
   flm_rsp_if          rsp,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data,
   output int          fail_count,
   output int          pending,
   output int          results_seen
);
   import flm_pkg::*;

   localparam int PRINT_CAP = 200;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] offset;
      logic [35:0] duration;
      logic [19:0] rate;
      logic        rate_zero;
   } locator_result_t;

   locator_result_t expected_q[$];
   locator_result_t want;
   int mismatches = 0;
   int seen = 0;

   // predicted parser state
   logic [16:0]   window_limit;
   logic [31:0]   byte_pos;
   logic [23:0]   last_three;
   logic [23:0]   len_acc;
   flm_phase_type phase;
   logic [23:0]   field_cnt;
   logic [31:0]   hdr_start;
   logic          info_last;
   logic [23:0]   rate_acc;
   logic [35:0]   samples;
   logic          done;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      if (mismatches < PRINT_CAP)
         $display("[%0t] rsp %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
      mismatches++;
   endtask

   task automatic clear_parse();
      byte_pos   = '0;
      last_three = '0;
      len_acc    = '0;
      phase      = PH_SEARCH;
      field_cnt  = '0;
      hdr_start  = '0;
      info_last  = 1'b0;
      rate_acc   = '0;
      samples    = '0;
      done       = 1'b0;
   endtask

   task automatic post_result(input logic [2:0] code, input logic [31:0] offset,
                              input logic timing);
      locator_result_t r;
      r = '0;
      r.status = code;
      r.offset = offset;
      if (timing) begin
         r.rate = rate_acc[19:0];
         if (rate_acc == '0) r.rate_zero = 1'b1;
         else r.duration = samples / {12'd0, rate_acc};
      end
      expected_q.push_back(r);
      done  = 1'b1;
      phase = PH_DONE;
   endtask

   task automatic locate_step(input logic [7:0] b, input logic eof);
      logic [31:0] at;
      logic [23:0] idx;
      logic        hit;
      at  = byte_pos;
      idx = field_cnt;
      hit = 1'b0;
      if (!done) begin
         case (phase)
            PH_SEARCH: begin
               if (last_three == SIG_HEAD && b == SIG_TAIL && at >= 32'd3 &&
                   33'(at - 32'd3) < 33'(window_limit)) begin
                  phase     = PH_INFO;
                  field_cnt = '0;
                  hdr_start = at + 32'd1;
               end else if (33'(at) + 33'd1 >= 33'(window_limit) + 33'd3) begin
                  post_result(STATUS_NO_SIG, '0, 1'b0);
                  hit = 1'b1;
               end
               last_three = {last_three[15:0], b};
            end
            PH_INFO: begin
               if (idx == '0) begin
                  info_last = b[7];
                  if (b[6:0] != 7'd0) begin
                     post_result(STATUS_NOT_INFO, '0, 1'b0);
                     hit = 1'b1;
                  end
               end else if (idx >= INFO_RATE_AT && idx < INFO_RATE_AT + 3) begin
                  rate_acc = {rate_acc[15:0], b};
                  if (idx == INFO_RATE_AT + 2) rate_acc = rate_acc >> 4;
               end else if (idx >= INFO_RATE_AT + 3 && idx < INFO_SIZE - 16) begin
                  if (idx == INFO_RATE_AT + 3) samples = {32'd0, b[3:0]};
                  else samples = {samples[27:0], b};
               end
               if (!hit) begin
                  idx = idx + 24'd1;
                  if (idx >= INFO_SIZE) begin
                     if (info_last) begin
                        post_result(STATUS_NO_COMMENT, '0, 1'b1);
                        hit = 1'b1;
                     end else begin
                        phase     = PH_HEADER;
                        field_cnt = '0;
                        hdr_start = at + 32'd1;
                     end
                  end else begin
                     field_cnt = idx;
                  end
               end
            end
            PH_HEADER: begin
               if (idx == '0) begin
                  if (b[6:0] == TYPE_COMMENT) begin
                     post_result(STATUS_COMMENT, hdr_start + 32'd4, 1'b1);
                     hit = 1'b1;
                  end else if (b[7]) begin
                     post_result(STATUS_NO_COMMENT, '0, 1'b1);
                     hit = 1'b1;
                  end else begin
                     len_acc   = '0;
                     field_cnt = 24'd1;
                  end
               end else begin
                  len_acc = {len_acc[15:0], b};
                  if (idx >= 24'd3) begin
                     // zero-length body: the next byte opens another header
                     if (len_acc == '0) begin
                        field_cnt = '0;
                        hdr_start = at + 32'd1;
                     end else begin
                        phase     = PH_SKIP;
                        field_cnt = len_acc;
                     end
                  end else begin
                     field_cnt = idx + 24'd1;
                  end
               end
            end
            PH_SKIP: begin
               field_cnt = field_cnt - 24'd1;
               if (field_cnt == '0) begin
                  phase     = PH_HEADER;
                  hdr_start = at + 32'd1;
               end
            end
            default: ;
         endcase
      end
      byte_pos = at + 32'd1;
      if (eof) begin
         // a result caused by the final byte itself wins
         if (!done && !hit)
            post_result(phase == PH_SEARCH ? STATUS_NO_SIG : STATUS_EARLY_EOF, '0, 1'b0);
         clear_parse();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         window_limit = 17'(MAX_SEARCH);
         expected_q.delete();
      end else begin
         // predict first so a same-edge result still finds its expectation
         if (req.valid && req.ready) locate_step(req.data_byte, req.end_of_file);
         if (rsp.valid && rsp.ready) begin
            seen++;
            if (expected_q.size() == 0) begin
               report_mismatch("beat with nothing pending, status", rsp.status, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", rsp.status, want.status);
               if (rsp.comment_offset !== want.offset)
                  report_mismatch("comment_offset", rsp.comment_offset, want.offset);
               if (rsp.duration_seconds !== want.duration)
                  report_mismatch("duration_seconds", rsp.duration_seconds, want.duration);
               if (rsp.sample_rate !== want.rate)
                  report_mismatch("sample_rate", rsp.sample_rate, want.rate);
               if (rsp.rate_zero !== want.rate_zero)
                  report_mismatch("rate_zero", rsp.rate_zero, want.rate_zero);
            end
         end
         if (csr_write_enable) window_limit = csr_write_data;
      end
      fail_count   <= mismatches;
      pending      <= expected_q.size();
      results_seen <= seen;
   end

endmodule

// File: bench/tb_flac_metadata_locator_top.sv
`timescale 1ns / 1ps

module tb_flac_metadata_locator_top;
   import flm_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE       = 64;
   localparam int RANDOM_BYTES = 1300;
   localparam int MIN_FILES    = 16;
   localparam int PLAN_LEN     = 8;

   typedef enum {RX_OPEN, RX_COIN, RX_DUTY} rx_mode_t;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [16:0] csr_write_data;
   int          fail_count;
   int          pending;
   int          results_seen;
   int          idle_cycles = 0;
   int          limit_now;
   int          burst_left;
   int          bytes_sent;
   int          files_sent;
   int          settings_used;
   logic [7:0]  file_q[$];

   flm_req_if req_bus();
   flm_rsp_if rsp_bus();

   flac_metadata_locator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   flm_locator_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .results_seen     (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat on either channel for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: switch between open, coin-flip and duty-cycle stalls
   initial begin
      rx_mode_t mode;
      int span, on_len, off_len;
      rsp_bus.ready <= 1'b0;
      forever begin
         mode    = rx_mode_t'($urandom_range(0, 2));
         span    = $urandom_range(30, 300);
         on_len  = $urandom_range(1, 6);
         off_len = $urandom_range(1, 40);
         for (int tick = 0; tick < span; tick++) begin
            @(posedge clock);
            case (mode)
               RX_OPEN: rsp_bus.ready <= 1'b1;
               RX_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= (tick % (on_len + off_len)) < on_len;
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) gap = 0;
         else if ($urandom_range(0, 5) == 0) gap = $urandom_range(6, 24);
         else gap = $urandom_range(1, 3);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.end_of_file <= eof;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      bytes_sent++;
   endtask

   // hold the sender until every predicted result is back, then let the divider settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_limit(input int value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= 17'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_now = value;
      settings_used++;
   endtask

   task automatic add_junk(input int count);
      repeat (count) file_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_signature();
      file_q.push_back(SIG_HEAD[23:16]);
      file_q.push_back(SIG_HEAD[15:8]);
      file_q.push_back(SIG_HEAD[7:0]);
      file_q.push_back(SIG_TAIL);
   endtask

   task automatic add_stream_info(input logic last, input logic [6:0] kind,
                                  input logic [19:0] rate, input logic [35:0] count);
      file_q.push_back({last, kind});
      add_junk(INFO_RATE_AT - 1);
      file_q.push_back(rate[19:12]);
      file_q.push_back(rate[11:4]);
      file_q.push_back({rate[3:0], 4'($urandom_range(0, 15))});
      file_q.push_back({4'($urandom_range(0, 15)), count[35:32]});
      file_q.push_back(count[31:24]);
      file_q.push_back(count[23:16]);
      file_q.push_back(count[15:8]);
      file_q.push_back(count[7:0]);
      add_junk(INFO_SIZE - INFO_RATE_AT - 8);
   endtask

   task automatic add_block_header(input logic last, input logic [6:0] kind,
                                   input logic [23:0] len);
      file_q.push_back({last, kind});
      file_q.push_back(len[23:16]);
      file_q.push_back(len[15:8]);
      file_q.push_back(len[7:0]);
   endtask

   // send the first keep bytes (all when keep is 0), end_of_file on the last one
   task automatic send_file(input int keep);
      int n;
      n = (keep > 0 && keep < file_q.size()) ? keep : file_q.size();
      for (int i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
      file_q.delete();
      files_sent++;
   endtask

   task automatic random_file();
      int          pre, nblk, len, keep;
      logic [6:0]  kind;
      logic [19:0] rate;
      logic [35:0] count;
      logic        last_blk;
      // aim some files at the edge of a narrow window
      if (limit_now <= 40 && $urandom_range(0, 5) == 0)
         pre = limit_now - 2 + $urandom_range(0, 3);
      else
         pre = $urandom_range(0, limit_now < 6 ? limit_now - 1 : 5);
      if (pre < 0) pre = 0;
      add_junk(pre);
      if ($urandom_range(0, 19) != 0) add_signature();
      else add_junk($urandom_range(0, 12));
      case ($urandom_range(0, 9))
         0: rate = '0;
         1: rate = 20'd1;
         2: rate = '1;
         3: rate = 20'd44100;
         default: rate = 20'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: count = '0;
         1: count = '1;
         default: count = 36'({$urandom, $urandom});
      endcase
      kind = ($urandom_range(0, 11) == 0) ? 7'($urandom_range(1, 127)) : 7'd0;
      add_stream_info($urandom_range(0, 9) == 0, kind, rate, count);
      nblk = $urandom_range(0, 4);
      for (int i = 0; i < nblk; i++) begin
         kind = 7'($urandom_range(0, 127));
         if (kind == TYPE_COMMENT && $urandom_range(0, 1) == 1) kind = 7'd1;
         last_blk = ($urandom_range(0, 19) == 0);
         len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         if (i == nblk - 1) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: kind = TYPE_COMMENT;
               4, 5, 6:    last_blk = 1'b1;
               default:    ;
            endcase
            if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 24'hFFFFFF);
         end
         add_block_header(last_blk, kind, 24'(len));
         add_junk(len < 20 ? len : 20);
      end
      add_junk($urandom_range(0, 3));
      keep = ($urandom_range(0, 6) == 0) ? $urandom_range(1, file_q.size()) : 0;
      send_file(keep);
   endtask

   initial begin
      int plan[PLAN_LEN];
      int start_bytes, start_files;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.end_of_file <= 1'b0;
      limit_now     = FLM_MAX_SEARCH;
      burst_left    = 0;
      bytes_sent    = 0;
      files_sent    = 0;
      settings_used = 1;
      plan = '{8192, 17, 1, 65536, 0, 65535, 0, 4};
      plan[4] = $urandom_range(2, 64);
      plan[6] = $urandom_range(1, 65536);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // comment found after a zero-length block; trailing bytes dropped
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd44100, 36'd1323000);
      add_block_header(1'b0, 7'd1, 24'd0);
      add_block_header(1'b1, TYPE_COMMENT, 24'd5);
      add_junk(5);
      send_file(0);
      // stream info marked last, zero rate
      add_junk(3);
      add_signature();
      add_stream_info(1'b1, 7'd0, 20'd0, 36'({$urandom, $urandom}));
      send_file(0);
      // first block is not stream info
      add_signature();
      add_stream_info(1'b0, 7'd3, 20'd48000, 36'd96000);
      send_file(0);
      // widest rate and count, last block without comment
      add_signature();
      add_stream_info(1'b0, 7'd0, '1, '1);
      add_block_header(1'b0, 7'h7F, 24'd2);
      add_junk(2);
      add_block_header(1'b1, 7'd6, 24'd3);
      add_junk(3);
      send_file(0);
      // comment header byte is also the end of file
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd1, '1);
      add_block_header(1'b0, 7'd2, 24'd1);
      add_junk(1);
      add_block_header(1'b0, TYPE_COMMENT, 24'd0);
      send_file(file_q.size() - 3);
      // end of file while searching, and a one-byte file
      add_junk(10);
      send_file(0);
      add_junk(1);
      send_file(0);
      // end of file on the byte that completes the signature
      add_signature();
      send_file(0);
      // end of file inside stream info
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd32000, 36'd64000);
      send_file(4 + 20);
      // end of file inside the longest skip
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd8000, 36'd80000);
      add_block_header(1'b0, 7'd1, '1);
      add_junk(8);
      send_file(0);
      // end of file right after a zero-length block header
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd22050, 36'd22050);
      add_block_header(1'b0, 7'd1, 24'd0);
      send_file(0);
      // end of file on the byte that completes a last stream info
      add_signature();
      add_stream_info(1'b1, 7'd0, 20'd96000, 36'd960000);
      send_file(0);

      // narrowest window: start 0 passes, start 1 does not
      set_limit(1);
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd44100, 36'd441000);
      add_block_header(1'b0, TYPE_COMMENT, 24'd4);
      send_file(0);
      add_junk(1);
      add_signature();
      add_junk(6);
      send_file(0);
      set_limit(4);
      add_junk(3);
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd48000, 36'd4800000);
      add_block_header(1'b1, TYPE_COMMENT, 24'd4);
      send_file(0);
      add_junk(4);
      add_signature();
      add_junk(4);
      send_file(0);
      // wider window: signature at the last allowed start
      set_limit(40);
      add_junk(39);
      add_signature();
      add_stream_info(1'b0, 7'd0, 20'd44100, 36'd88200);
      add_block_header(1'b0, TYPE_COMMENT, 24'd2);
      send_file(0);

      start_bytes = bytes_sent;
      start_files = files_sent;
      for (int p = 0; p < PLAN_LEN; p++) begin
         set_limit(plan[p]);
         while (bytes_sent - start_bytes < RANDOM_BYTES * (p + 1) / PLAN_LEN ||
                files_sent - start_files < MIN_FILES * (p + 1) / PLAN_LEN) begin
            random_file();
            if ($urandom_range(0, 15) == 0) drain();
         end
      end
      drain();

      $display("Sent %0d file bytes in %0d files under %0d search-window settings.",
               bytes_sent, files_sent, settings_used);
      $display("Checked %0d result beats field by field; %0d mismatches.",
               results_seen, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
